>>> src/sctcr_pkg.sv
// ----------------------------------------------------------------------------
// sctcr_pkg
// Types, constants and helper functions for the score total competition
// ranking block.
// ----------------------------------------------------------------------------
package sctcr_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int SUBJECTS    = 4;
    localparam int SCORE_FIELDS = 4;

    // fixed field widths of the channels
    localparam int SCORE_W = 7;
    localparam int INDEX_W = 6;
    localparam int TOTAL_W = 9;
    localparam int RANK_W  = 7;
    localparam int GRADE_W = 3;

    // store addressing and record counting
    localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    localparam logic [SCORE_W-1:0] SCORE_CAP = SCORE_W'(100);

    // grade boundaries: class = floor(total / (SUBJECTS * 10))
    localparam int CLASS_DIV = SUBJECTS * 10;
    localparam logic [TOTAL_W:0] GRADE_A_MIN = (TOTAL_W + 1)'(9 * CLASS_DIV);
    localparam logic [TOTAL_W:0] GRADE_B_MIN = (TOTAL_W + 1)'(8 * CLASS_DIV);
    localparam logic [TOTAL_W:0] GRADE_C_MIN = (TOTAL_W + 1)'(7 * CLASS_DIV);
    localparam logic [TOTAL_W:0] GRADE_D_MIN = (TOTAL_W + 1)'(6 * CLASS_DIV);

    localparam logic [GRADE_W-1:0] GRADE_A = 3'd0;
    localparam logic [GRADE_W-1:0] GRADE_B = 3'd1;
    localparam logic [GRADE_W-1:0] GRADE_C = 3'd2;
    localparam logic [GRADE_W-1:0] GRADE_D = 3'd3;
    localparam logic [GRADE_W-1:0] GRADE_F = 3'd4;

    typedef struct packed {
        logic [SCORE_W-1:0] score_a;
        logic [SCORE_W-1:0] score_b;
        logic [SCORE_W-1:0] score_c;
        logic [SCORE_W-1:0] score_d;
        logic               last_record;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] record_index;
        logic [TOTAL_W-1:0] score_total;
        logic [RANK_W-1:0]  competition_rank;
        logic [GRADE_W-1:0] grade_class;
        logic               last_result;
    } result_t;

    // record handed from the front end to the ranking unit
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               last;
    } record_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CAPTURE,
        ST_SWEEP,
        ST_WAIT
    } rank_state_t;

    function automatic logic [SCORE_W-1:0] clamp_score(input logic [SCORE_W-1:0] s);
        return (s > SCORE_CAP) ? SCORE_CAP : s;
    endfunction

    function automatic logic [GRADE_W-1:0] grade_of(input logic [TOTAL_W-1:0] total);
        logic [TOTAL_W:0] t;
        logic [GRADE_W-1:0] g;
        t = {1'b0, total};
        priority if (t >= GRADE_A_MIN) g = GRADE_A;
        else if (t >= GRADE_B_MIN)     g = GRADE_B;
        else if (t >= GRADE_C_MIN)     g = GRADE_C;
        else if (t >= GRADE_D_MIN)     g = GRADE_D;
        else                           g = GRADE_F;
        return g;
    endfunction

endpackage

>>> src/sctcr_rank.sv
// ----------------------------------------------------------------------------
// sctcr_rank
// Total store and ranking sequencer: one comparator is swept over the stored
// totals for each record, then the result is handed to the output register.
// ----------------------------------------------------------------------------
module sctcr_rank (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rec_valid,
    output logic                rec_stall,
    input  sctcr_pkg::record_t  rec,
    output logic                result_valid,
    input  logic                result_stall,
    output sctcr_pkg::result_t  result
);
    import sctcr_pkg::*;

    rank_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [TOTAL_W-1:0] t_reg, t_next;
    logic [RANK_W-1:0]  rank_reg, rank_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic [TOTAL_W-1:0] mem [MAX_RECORDS];
    logic [TOTAL_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic               accept;
    logic               greater;
    logic               slot_free;
    logic               final_rec;

    assign rec_stall    = (state_reg != ST_IDLE);
    assign accept       = rec_valid && (state_reg == ST_IDLE);
    assign wr_en        = accept && (count_reg < CNT_W'(MAX_RECORDS));
    assign greater      = (rd_data_reg > t_reg);
    assign slot_free    = !out_valid_reg || !result_stall;
    assign final_rec    = ((idx_reg + CNT_W'(1)) == count_reg);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= rec.total;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        rank_reg <= rank_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        t_next         = t_reg;
        rank_next      = rank_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        rd_addr        = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // a full store drops the record but still honours its last flag
                    if (wr_en)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (rec.last)
                    begin
                        idx_next = '0;
                        if (count_next == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_FETCH;
                        end
                    end
                end
            end
            ST_FETCH:
            begin
                rd_addr    = idx_reg[IDX_W-1:0];
                state_next = ST_CAPTURE;
            end
            ST_CAPTURE:
            begin
                // own total arrives; start the sweep from entry zero
                t_next     = rd_data_reg;
                rd_addr    = '0;
                k_next     = CNT_W'(1);
                rank_next  = RANK_W'(1);
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                // rd_data_reg holds entry k_reg - 1
                rd_addr = k_reg[IDX_W-1:0];
                if (greater)
                begin
                    rank_next = rank_reg + RANK_W'(1);
                end
                if (k_reg < count_reg)
                begin
                    k_next = k_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (slot_free)
                begin
                    out_valid_next            = 1'b1;
                    out_next.record_index     = INDEX_W'(idx_reg);
                    out_next.score_total      = t_reg;
                    out_next.competition_rank = rank_reg;
                    out_next.grade_class      = grade_of(t_reg);
                    out_next.last_result      = final_rec;
                    if (final_rec)
                    begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/score_total_competition_rank.sv
// ----------------------------------------------------------------------------
// score_total_competition_rank
// Clamps and sums four subject scores per record, stores the totals and, on
// the last record, emits each record's total, competition rank and grade.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  item      in         item_valid/item_stall item   (sctcr_pkg::item_t)
//  result    out        result_valid/...stall result (sctcr_pkg::result_t)
//
//  A record that is not last is taken while the sequencer is idle.  After the
//  last record, each stored record is fetched, captured, ranked by a sweep of
//  the single comparator over the total store and handed off; item_stall stays
//  high for the whole ranking burst.  Reset clears the record count and the
//  sequencer; the store is not cleared.  A stalled result holds in the output
//  register while the next is ranked.
// ----------------------------------------------------------------------------
module score_total_competition_rank (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  sctcr_pkg::item_t   item,
    output logic               result_valid,
    input  logic               result_stall,
    output sctcr_pkg::result_t result
);
    import sctcr_pkg::*;

    logic [SCORE_W-1:0] scores [SCORE_FIELDS];
    logic [TOTAL_W-1:0] total;
    record_t            rec;

    assign scores[0] = item.score_a;
    assign scores[1] = item.score_b;
    assign scores[2] = item.score_c;
    assign scores[3] = item.score_d;

    // only the first SUBJECTS fields count
    always_comb
    begin
        total = '0;
        for (int j = 0; j < SCORE_FIELDS; j++)
        begin
            if (j < SUBJECTS)
            begin
                total = total + TOTAL_W'(clamp_score(scores[j]));
            end
        end
    end

    assign rec.total = total;
    assign rec.last  = item.last_record;

    sctcr_rank u_rank (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec_valid    (item_valid),
        .rec_stall    (item_stall),
        .rec          (rec),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for score_total_competition_rank. A short table of
// directed sets is run first: single records with hand-worked results, grade
// boundaries and tied totals. Random sets follow, including one full store and
// one overflowing store, under three flow-control regimes. Every result is
// compared field by field with a software ranker.
// ----------------------------------------------------------------------------
module tb_top;
    import sctcr_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 212;
    localparam int REPORT_CAP   = 40;

    typedef struct packed {
        item_t   rec;
        bit      typed;
        result_t want;
    } stim_row_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // ranker state
    logic [TOTAL_W-1:0] totals_held [MAX_RECORDS];
    int unsigned        held_count = 0;
    result_t            expected_results [$];

    stim_row_t   directed_rows [$];
    int unsigned error_count    = 0;
    int unsigned results_seen   = 0;
    int unsigned records_sent   = 0;
    int unsigned sets_sent      = 0;
    int unsigned cycle_count    = 0;
    int unsigned gap_pct        = 0;
    int unsigned stall_pct      = 0;

    score_total_competition_rank uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (error_count < REPORT_CAP)
            $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic logic [GRADE_W-1:0] grade_band(input logic [TOTAL_W-1:0] total);
        int unsigned band;
        band = total / (SUBJECTS * 10);
        if (band >= 9)
            return GRADE_A;
        if (band == 8)
            return GRADE_B;
        if (band == 7)
            return GRADE_C;
        if (band == 6)
            return GRADE_D;
        return GRADE_F;
    endfunction

    // Store one record's total; on the last record rank the whole set.
    task automatic absorb_record(input item_t rec);
        logic [SCORE_W-1:0] scores [0:3];
        int unsigned        sum;
        int unsigned        rank;
        result_t            r;
        scores[0] = rec.score_a;
        scores[1] = rec.score_b;
        scores[2] = rec.score_c;
        scores[3] = rec.score_d;
        sum = 0;
        for (int j = 0; j < SUBJECTS && j < 4; j++)
            sum += (scores[j] > SCORE_CAP) ? int'(SCORE_CAP) : int'(scores[j]);
        // a full store drops the record but still honours its last flag
        if (held_count < MAX_RECORDS)
        begin
            totals_held[held_count] = sum[TOTAL_W-1:0];
            held_count++;
        end
        if (rec.last_record)
        begin
            for (int i = 0; i < held_count; i++)
            begin
                rank = 1;
                for (int k = 0; k < held_count; k++)
                    if (totals_held[k] > totals_held[i])
                        rank++;
                r.record_index     = i[INDEX_W-1:0];
                r.score_total      = totals_held[i];
                r.competition_rank = rank[RANK_W-1:0];
                r.grade_class      = grade_band(totals_held[i]);
                r.last_result      = (i + 1 == held_count);
                expected_results.push_back(r);
            end
            held_count = 0;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch("result with nothing outstanding, index",
                                result.record_index, 0);
            else
            begin
                want = expected_results.pop_front();
                if (result.record_index !== want.record_index)
                    report_mismatch("record_index", result.record_index, want.record_index);
                if (result.score_total !== want.score_total)
                    report_mismatch("score_total", result.score_total, want.score_total);
                if (result.competition_rank !== want.competition_rank)
                    report_mismatch("competition_rank", result.competition_rank,
                                    want.competition_rank);
                if (result.grade_class !== want.grade_class)
                    report_mismatch("grade_class", result.grade_class, want.grade_class);
                if (result.last_result !== want.last_result)
                    report_mismatch("last_result", result.last_result, want.last_result);
            end
        end
    end

    task automatic add_row(input int unsigned a, input int unsigned b, input int unsigned c,
                           input int unsigned d, input bit last_rec, input bit typed,
                           input int unsigned total, input logic [GRADE_W-1:0] grade);
        stim_row_t row;
        row.rec.score_a            = a[SCORE_W-1:0];
        row.rec.score_b            = b[SCORE_W-1:0];
        row.rec.score_c            = c[SCORE_W-1:0];
        row.rec.score_d            = d[SCORE_W-1:0];
        row.rec.last_record        = last_rec;
        row.typed                  = typed;
        // typed rows are sets of one record: index 0, rank 1, last result
        row.want.record_index      = '0;
        row.want.score_total       = total[TOTAL_W-1:0];
        row.want.competition_rank  = RANK_W'(1);
        row.want.grade_class       = grade;
        row.want.last_result       = 1'b1;
        directed_rows.push_back(row);
    endtask

    // One transaction on the item channel, with a random gap ahead of it.
    task automatic send_record(input item_t rec);
        while ($urandom_range(99) < gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= rec;
        do
            @(posedge clk);
        while (item_stall);
        absorb_record(rec);
        records_sent++;
        if (rec.last_record)
            sets_sent++;
    endtask

    function automatic logic [SCORE_W-1:0] pick_score(input bit tie_mode);
        if (tie_mode)
            return SCORE_W'(25 * $urandom_range(0, 4));
        if ($urandom_range(99) < 15)
            return SCORE_W'($urandom_range(101, 127));
        return SCORE_W'($urandom_range(0, 100));
    endfunction

    task automatic send_set(input int unsigned n_recs, input bit tie_mode);
        item_t rec;
        for (int k = 0; k < n_recs; k++)
        begin
            rec.score_a     = pick_score(tie_mode);
            rec.score_b     = pick_score(tie_mode);
            rec.score_c     = pick_score(tie_mode);
            rec.score_d     = pick_score(tie_mode);
            rec.last_record = (k == n_recs - 1);
            send_record(rec);
        end
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_flow(input int unsigned phase);
        case (phase)
            0:
            begin
                gap_pct   = 13;
                stall_pct = 52;
            end
            1:
            begin
                gap_pct   = 52;
                stall_pct = 13;
            end
            default:
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
        endcase
    endtask

    initial
    begin
        int unsigned n_directed;
        int unsigned phase;
        int unsigned cur_phase;
        int unsigned set_no;
        int unsigned n_recs;

        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;

        // single records: floor, ceiling, clamping of every score, one clamp only
        add_row(0,   0,   0,   0,   1, 1, 0,   GRADE_F);
        add_row(100, 100, 100, 100, 1, 1, 400, GRADE_A);
        add_row(127, 127, 127, 127, 1, 1, 400, GRADE_A);
        add_row(101, 100, 0,   0,   1, 1, 200, GRADE_F);
        // grade boundaries either side, ranked as one set
        add_row(90, 90, 90, 90, 0, 0, 0, GRADE_F);
        add_row(90, 90, 90, 89, 0, 0, 0, GRADE_F);
        add_row(80, 80, 80, 80, 0, 0, 0, GRADE_F);
        add_row(80, 80, 80, 79, 0, 0, 0, GRADE_F);
        add_row(70, 70, 70, 70, 0, 0, 0, GRADE_F);
        add_row(70, 70, 70, 69, 0, 0, 0, GRADE_F);
        add_row(60, 60, 60, 60, 0, 0, 0, GRADE_F);
        add_row(60, 60, 60, 59, 1, 0, 0, GRADE_F);
        // equal totals share a rank
        add_row(25,  25,  25,  25,  0, 0, 0, GRADE_F);
        add_row(100, 0,   0,   0,   0, 0, 0, GRADE_F);
        add_row(0,   100, 0,   0,   0, 0, 0, GRADE_F);
        add_row(0,   0,   100, 0,   0, 0, 0, GRADE_F);
        add_row(0,   0,   0,   100, 0, 0, 0, GRADE_F);
        add_row(60,  60,  60,  60,  1, 0, 0, GRADE_F);
        n_directed = directed_rows.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        cur_phase = 0;
        set_flow(cur_phase);
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            send_record(directed_rows[r].rec);
            if (directed_rows[r].typed)
                expected_results[expected_results.size() - 1] = directed_rows[r].want;
        end
        // hold off until the directed results are all back
        item_valid <= 1'b0;
        wait_drained();

        set_no = 0;
        while (records_sent < n_directed + RANDOM_ITEMS)
        begin
            phase = ((records_sent - n_directed) * 3) / RANDOM_ITEMS;
            if (phase > 2)
                phase = 2;
            if (phase != cur_phase)
            begin
                item_valid <= 1'b0;
                wait_drained();
                cur_phase = phase;
                set_flow(cur_phase);
            end
            if (set_no == 3)
                n_recs = MAX_RECORDS;
            else if (set_no == 9)
                n_recs = MAX_RECORDS + 2;   // last two records fall off a full store
            else if ($urandom_range(9) == 0)
                n_recs = $urandom_range(9, 24);
            else
                n_recs = $urandom_range(1, 8);
            send_set(n_recs, $urandom_range(2) == 0);
            set_no++;
        end

        item_valid <= 1'b0;
        wait_drained();
        repeat (60) @(posedge clk);

        $display("Sent %0d records in %0d sets (one full, one overflowing store)",
                 records_sent, sets_sent);
        $display("Checked %0d ranked results, %0d mismatches", results_seen, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
src/sctcr_pkg.sv
src/sctcr_rank.sv
src/score_total_competition_rank.sv
tb/tb_top.sv
